@@ rtl/krcf_pkg.sv @@
// Shared types and codes for the keyed revision cache.
// Request and response payloads, action and status codes, controller links.
// No dependencies.
package krcf_pkg;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_GET   = 2'd1;
  localparam logic [1:0] ACT_INVAL = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic STS_OK      = 1'b0;
  localparam logic STS_BAD_ARG = 1'b1;

  localparam int KEY_W   = 64;
  localparam int REV_W   = 64;
  localparam int SCORE_W = 32;
  localparam int OCC_W   = 5;

  typedef struct packed {
    logic [1:0]         action;
    logic [KEY_W-1:0]   entry_key;
    logic [REV_W-1:0]   entry_revision;
    logic [SCORE_W-1:0] entry_score;
  } krcf_in_t;

  typedef struct packed {
    logic               status;
    logic               hit;
    logic [SCORE_W-1:0] found_score;
    logic [OCC_W-1:0]   occupancy;
  } krcf_out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic put_upd;
    logic put_new;
    logic inval_clr;
    logic get_hit;
    logic emit;
  } krcf_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       skip;
    logic       cmp_vld;
    logic       cmp_last;
    logic       key_match;
    logic       full_match;
    logic       is_old;
    logic       out_busy;
  } krcf_sts_t;

endpackage

@@ rtl/krcf_datapath.sv @@
// Datapath for the keyed revision cache: slot memories, valid bits, victim
// pointer, occupancy count, scan pipeline and response register.
// Depends on krcf_pkg.
module krcf_datapath import krcf_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  krcf_in_t  in_req,
  input  logic      out_ready,
  output logic      out_valid,
  output krcf_out_t out_rsp,
  input  krcf_cmd_t cmd,
  output krcf_sts_t sts
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_SLOTS);

  logic [KEY_W-1:0]   key_mem   [NUM_SLOTS];
  logic [REV_W-1:0]   rev_mem   [NUM_SLOTS];
  logic [SCORE_W-1:0] score_mem [NUM_SLOTS];

  krcf_in_t           req_r;
  logic [NUM_SLOTS-1:0] valid_r;
  logic [IDX_W-1:0]   victim_r, victim_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   scan_idx_r;
  logic               rd_more_r;
  logic               cmp_vld_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic [KEY_W-1:0]   key_q_r;
  logic [REV_W-1:0]   rev_q_r;
  logic [SCORE_W-1:0] score_q_r;
  logic               hit_r;
  logic [SCORE_W-1:0] score_r;
  logic               out_valid_r;
  krcf_out_t          out_r;
  logic               slot_ok;
  logic               bad_put;

  assign slot_ok = valid_r[cmp_idx_r];
  assign bad_put = (req_r.action == ACT_PUT) && (req_r.entry_key == '0);

  always_comb begin
    sts            = '0;
    sts.action     = req_r.action;
    sts.skip       = bad_put || (req_r.action == ACT_NONE);
    sts.cmp_vld    = cmp_vld_r;
    sts.cmp_last   = (cmp_idx_r == LAST_IDX);
    sts.key_match  = slot_ok && (key_q_r == req_r.entry_key);
    sts.full_match = slot_ok && (key_q_r == req_r.entry_key)
                     && (rev_q_r == req_r.entry_revision);
    sts.is_old     = slot_ok && (rev_q_r < req_r.entry_revision);
    sts.out_busy   = out_valid_r && !out_ready;
  end

  always_comb begin
    victim_nxt = (victim_r == LAST_IDX) ? '0 : victim_r + 1'b1;
    count_nxt  = count_r;
    priority if (cmd.put_new && (count_r < FULL_CNT)) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.inval_clr && (count_r != '0)) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      victim_r    <= '0;
      count_r     <= '0;
      scan_idx_r  <= '0;
      rd_more_r   <= 1'b0;
      cmp_vld_r   <= 1'b0;
      cmp_idx_r   <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load) begin
        scan_idx_r <= '0;
        rd_more_r  <= 1'b1;
        cmp_vld_r  <= 1'b0;
        hit_r      <= 1'b0;
      end else if (cmd.step) begin
        if (rd_more_r) begin
          scan_idx_r <= scan_idx_r + 1'b1;
          rd_more_r  <= (scan_idx_r != LAST_IDX);
          cmp_idx_r  <= scan_idx_r;
        end
        cmp_vld_r <= rd_more_r;
      end
      if (cmd.put_new) begin
        valid_r[victim_r] <= 1'b1;
        victim_r          <= victim_nxt;
      end
      if (cmd.inval_clr) begin
        valid_r[cmp_idx_r] <= 1'b0;
      end
      if (cmd.get_hit) begin
        hit_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req;
      score_r <= '0;
    end
    if (cmd.step && rd_more_r) begin
      key_q_r   <= key_mem[scan_idx_r];
      rev_q_r   <= rev_mem[scan_idx_r];
      score_q_r <= score_mem[scan_idx_r];
    end
    if (cmd.put_upd) begin
      rev_mem[cmp_idx_r]   <= req_r.entry_revision;
      score_mem[cmp_idx_r] <= req_r.entry_score;
    end
    if (cmd.put_new) begin
      key_mem[victim_r]   <= req_r.entry_key;
      rev_mem[victim_r]   <= req_r.entry_revision;
      score_mem[victim_r] <= req_r.entry_score;
    end
    if (cmd.get_hit) begin
      score_r <= score_q_r;
    end
    if (cmd.emit) begin
      out_r.status      <= bad_put ? STS_BAD_ARG : STS_OK;
      out_r.hit         <= hit_r;
      out_r.found_score <= score_r;
      out_r.occupancy   <= OCC_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("occupancy count above capacity");

  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put_new && (count_r < FULL_CNT) |=> count_r == $past(count_r) + 1'b1)
    else $error("count not raised on new entry");

  a_clr_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.inval_clr |-> slot_ok && (req_r.action == ACT_INVAL))
    else $error("clear of an invalid slot or outside invalidate");

endmodule

@@ rtl/krcf_ctrl.sv @@
// Controller for the keyed revision cache: sequences load, slot scan,
// write-back and response hand-off.
// Depends on krcf_pkg.
module krcf_ctrl import krcf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  krcf_sts_t sts,
  output krcf_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        priority if (sts.skip) begin
          state_nxt = S_EMIT;
        end else if (sts.cmp_vld) begin
          unique case (sts.action)
            ACT_PUT: begin
              priority if (sts.key_match) begin
                cmd.put_upd = 1'b1;
                state_nxt   = S_EMIT;
              end else if (sts.cmp_last) begin
                cmd.put_new = 1'b1;
                state_nxt   = S_EMIT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ACT_GET: begin
              priority if (sts.full_match) begin
                cmd.get_hit = 1'b1;
                state_nxt   = S_EMIT;
              end else if (sts.cmp_last) begin
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ACT_INVAL: begin
              cmd.inval_clr = sts.is_old;
              if (sts.cmp_last) begin
                state_nxt = S_EMIT;
              end
            end
            default: state_nxt = S_EMIT;
          endcase
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.put_upd, cmd.put_new, cmd.inval_clr, cmd.get_hit}))
    else $error("more than one table update at once");

  a_write_on_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.put_upd || cmd.put_new || cmd.inval_clr || cmd.get_hit)
      |-> sts.cmp_vld && !sts.skip)
    else $error("table update without a compared slot");

endmodule

@@ rtl/keyed_revision_cache_fifo.sv @@
// Channel   Ports                          Payload
// request   in_valid / in_ready            in_req  (krcf_in_t)
// response  out_valid / out_ready          out_rsp (krcf_out_t)
//
// Each request is loaded, then the registered slot-memory read is primed,
// then each slot is compared in turn, and last the response is handed over;
// a put or get that matches early ends its scan there. Zero-key puts and the
// unused action skip the compares and go straight to the response.
// Reset clears valid bits, victim pointer and count at once; no clearing pass.
// A response waiting on out_ready holds the next request in its final cycle.
// Depends on krcf_pkg, krcf_ctrl and krcf_datapath.
module keyed_revision_cache_fifo import krcf_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  krcf_in_t  in_req,
  output logic      out_valid,
  input  logic      out_ready,
  output krcf_out_t out_rsp
);

  krcf_cmd_t cmd;
  krcf_sts_t sts;

  krcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  krcf_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ bench/keyed_revision_cache_fifo_tb.sv @@
// Self-checking bench for keyed_revision_cache_fifo: directed and random requests, with
// responses checked in order against a slot-table predictor written in the bench.
// Depends on krcf_pkg and the keyed_revision_cache_fifo RTL.
module keyed_revision_cache_fifo_tb;
  import krcf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = 16;
  localparam int POOL_SIZE = 24;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  krcf_in_t  in_req    = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  krcf_out_t out_rsp;

  logic             tbl_valid [SLOTS];
  logic [KEY_W-1:0] tbl_key   [SLOTS];
  logic [REV_W-1:0] tbl_rev   [SLOTS];
  logic [SCORE_W-1:0] tbl_score [SLOTS];
  int               tbl_victim;
  int               tbl_count;

  krcf_out_t        pending_rsp [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               fail_count   = 0;
  int               tx_idle_pct  = 0;
  int               rx_idle_pct  = 0;
  int               rx_hold_left = 0;

  keyed_revision_cache_fifo #(
    .NUM_SLOTS(SLOTS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic krcf_out_t cache_predict(input krcf_in_t req);
    krcf_out_t rsp;
    logic      done;
    int        i;
    rsp  = '0;
    done = 1'b0;
    case (req.action)
      ACT_PUT: begin
        if (req.entry_key == '0) begin
          rsp.status = STS_BAD_ARG;
        end else begin
          for (i = 0; i < SLOTS; i++) begin
            if (!done && tbl_valid[i] && tbl_key[i] == req.entry_key) begin
              tbl_rev[i]   = req.entry_revision;
              tbl_score[i] = req.entry_score;
              done         = 1'b1;
            end
          end
          if (!done) begin
            tbl_key[tbl_victim]   = req.entry_key;
            tbl_rev[tbl_victim]   = req.entry_revision;
            tbl_score[tbl_victim] = req.entry_score;
            tbl_valid[tbl_victim] = 1'b1;
            tbl_victim            = (tbl_victim + 1) % SLOTS;
            if (tbl_count < SLOTS) tbl_count++;
          end
        end
      end
      ACT_GET: begin
        for (i = 0; i < SLOTS; i++) begin
          if (!done && tbl_valid[i] && tbl_key[i] == req.entry_key &&
              tbl_rev[i] == req.entry_revision) begin
            rsp.hit         = 1'b1;
            rsp.found_score = tbl_score[i];
            done            = 1'b1;
          end
        end
      end
      ACT_INVAL: begin
        for (i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_rev[i] < req.entry_revision) begin
            tbl_valid[i] = 1'b0;
            if (tbl_count > 0) tbl_count--;
          end
        end
      end
      default: begin
      end
    endcase
    rsp.occupancy = tbl_count[OCC_W-1:0];
    return rsp;
  endfunction

  function automatic krcf_in_t mk_req(input logic [1:0] action, input logic [KEY_W-1:0] key,
                                      input logic [REV_W-1:0] rev,
                                      input logic [SCORE_W-1:0] score);
    krcf_in_t req;
    req.action         = action;
    req.entry_key      = key;
    req.entry_revision = rev;
    req.entry_score    = score;
    return req;
  endfunction

  function automatic krcf_in_t random_req();
    krcf_in_t req;
    int       pick;
    req.entry_score = $urandom;
    if ($urandom_range(99) < 80) begin
      pick               = $urandom_range(99);
      req.action         = (pick < 45) ? ACT_PUT : (pick < 85) ? ACT_GET : ACT_INVAL;
      req.entry_key      = key_pool[$urandom_range(POOL_SIZE - 1)];
      req.entry_revision = REV_W'($urandom_range((req.action == ACT_INVAL) ? 4 : 3));
    end else begin
      req.action         = 2'($urandom_range(3));
      req.entry_key      = ($urandom_range(3) == 0) ? '0 : {$urandom, $urandom};
      req.entry_revision = ($urandom_range(3) == 0) ? '1 : {$urandom, $urandom};
    end
    return req;
  endfunction

  task automatic send_req(input krcf_in_t req);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    pending_rsp.push_back(cache_predict(req));
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_req(mk_req(ACT_GET, 64'd1, '0, '1));
    send_req(mk_req(ACT_NONE, '1, '1, '1));
    send_req(mk_req(ACT_INVAL, '0, '1, '0));
  endtask

  task automatic test_put_and_get();
    send_req(mk_req(ACT_PUT, '1, '1, '1));
    send_req(mk_req(ACT_GET, '1, '1, '0));
    send_req(mk_req(ACT_GET, '1, '0, '0));
    send_req(mk_req(ACT_PUT, '1, 64'd5, 32'hA5A5_5A5A));
    send_req(mk_req(ACT_PUT, 64'd1, '0, '0));
  endtask

  task automatic test_zero_key();
    send_req(mk_req(ACT_PUT, '0, 64'd7, 32'h1234_5678));
    send_req(mk_req(ACT_GET, '0, '0, '0));
  endtask

  task automatic test_fill_and_wrap();
    int i;
    for (i = 0; i < 15; i++) begin
      send_req(mk_req(ACT_PUT, 64'h100 + KEY_W'(i), REV_W'(i), $urandom));
    end
  endtask

  task automatic test_count_drift();
    send_req(mk_req(ACT_INVAL, '0, 64'd8, '0));
    send_req(mk_req(ACT_PUT, 64'h8000_0000_0000_0000, 64'd9, 32'hFFFF_0000));
    send_req(mk_req(ACT_GET, 64'h8000_0000_0000_0000, 64'd9, '0));
  endtask

  task automatic test_random_phase(input int tx_pct, input int rx_pct, input int count);
    int n;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (n = 0; n < count; n++) send_req(random_req());
  endtask

  task automatic test_backpressure();
    int n;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    @(negedge clk);
    rx_hold_left = 400;
    @(posedge clk);
    for (n = 0; n < 30; n++) send_req(random_req());
    hold_until_drained();
  endtask

  // receiver: random ready, or a long hold when requested
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(negedge clk) begin : rsp_check
    krcf_out_t exp_rsp;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        if (fail_count < 10) $display("unexpected response %p", out_rsp);
        fail_count++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (out_rsp.status !== exp_rsp.status || out_rsp.hit !== exp_rsp.hit ||
            out_rsp.found_score !== exp_rsp.found_score ||
            out_rsp.occupancy !== exp_rsp.occupancy) begin
          if (fail_count < 10) begin
            $display("response mismatch: expected status %0d hit %0d score %h occ %0d",
                     exp_rsp.status, exp_rsp.hit, exp_rsp.found_score, exp_rsp.occupancy);
            $display("                   actual   status %0d hit %0d score %h occ %0d",
                     out_rsp.status, out_rsp.hit, out_rsp.found_score, out_rsp.occupancy);
          end
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("keyed_revision_cache_fifo regression: fail");
    $finish;
  end

  initial begin
    int i;
    for (i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_rev[i]   = '0;
      tbl_score[i] = '0;
    end
    tbl_victim = 0;
    tbl_count  = 0;
    key_pool[0] = '1;
    key_pool[1] = 64'd1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    for (i = 3; i < POOL_SIZE; i++) begin
      key_pool[i] = {$urandom, $urandom} | 64'd1;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_put_and_get();
    test_zero_key();
    test_fill_and_wrap();
    test_count_drift();
    test_random_phase(9, 80, 600);
    test_random_phase(80, 9, 600);
    test_random_phase(0, 0, 600);
    test_backpressure();
    hold_until_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("keyed_revision_cache_fifo regression: pass");
    end else begin
      $display("keyed_revision_cache_fifo regression: fail");
    end
    $finish;
  end

endmodule
